FILE: rtl/ftcm_pkg.sv
// ----------------------------------------------------------------------------
// ftcm_pkg
// Shared types and constants for the fractal trace coordinate map.
// ----------------------------------------------------------------------------
package ftcm_pkg;

    localparam int FRAC_BITS = 24;
    localparam int OUT_FRAC  = 12;
    localparam int LIMIT_W   = 17;
    localparam logic [LIMIT_W-1:0] MAX_ITER = 17'd65536;

    // Back mapping divides a 64-bit magnitude widened by OUT_FRAC bits
    localparam int DIV_STEPS = 64 + OUT_FRAC;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Register indexes
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_LEFT    = 3'd1;
    localparam logic [2:0] REG_TOP     = 3'd2;
    localparam logic [2:0] REG_STEP_X  = 3'd3;
    localparam logic [2:0] REG_STEP_Y  = 3'd4;
    localparam logic [2:0] REG_SEED    = 3'd5;
    localparam logic [2:0] REG_LIMIT   = 3'd6;
    localparam logic [2:0] REG_BAILOUT = 3'd7;

    // Fractal modes
    localparam logic MODE_MANDELBROT = 1'b0;
    localparam logic MODE_JULIA      = 1'b1;

    // Product selectors within one iteration
    localparam logic [1:0] MUL_XX = 2'd0;
    localparam logic [1:0] MUL_YY = 2'd1;
    localparam logic [1:0] MUL_XY = 2'd2;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] left_edge;
        logic signed [31:0] top_edge;
        logic signed [31:0] step_x;
        logic signed [31:0] step_y;
        logic [63:0]        seed;
        logic [LIMIT_W-1:0] limit;
        logic [63:0]        bailout;
    } t_cfg;

    typedef struct packed {
        logic       load;
        logic       init_mul;
        logic       init_add;
        logic       prep;
        logic       mul;
        logic       acc;
        logic       fin;
        logic       upd1;
        logic       upd2;
        logic       bsub;
        logic       bmag;
        logic       div;
        logic       bfin;
        logic       out_load;
        logic [1:0] sel_m;
        logic [1:0] sel_p;
        logic       axis;
    } t_dp_cmd;

    typedef struct packed {
        logic esc;
        logic step_zero;
    } t_dp_sts;

endpackage

FILE: rtl/ftcm_regs.sv
// ----------------------------------------------------------------------------
// ftcm_regs
// APB-style configuration register file.
// ----------------------------------------------------------------------------
module ftcm_regs
    import ftcm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[5:3];
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_MANDELBROT;
            r_cfg.left_edge <= 32'shFF000000;
            r_cfg.top_edge  <= 32'shFF000000;
            r_cfg.step_x    <= 32'sh00004000;
            r_cfg.step_y    <= 32'sh00004000;
            r_cfg.seed      <= 64'h0080000000800000;
            r_cfg.limit     <= 17'd3;
            r_cfg.bailout   <= 64'd1677721600000000;
        end else if (wr_en) begin
            case (idx)
                REG_MODE:    r_cfg.mode      <= pwdata[0];
                REG_LEFT:    r_cfg.left_edge <= pwdata[31:0];
                REG_TOP:     r_cfg.top_edge  <= pwdata[31:0];
                REG_STEP_X:  r_cfg.step_x    <= pwdata[31:0];
                REG_STEP_Y:  r_cfg.step_y    <= pwdata[31:0];
                REG_SEED:    r_cfg.seed      <= pwdata;
                REG_LIMIT:   r_cfg.limit     <= pwdata[LIMIT_W-1:0];
                REG_BAILOUT: r_cfg.bailout   <= pwdata;
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (idx)
            REG_MODE:    prdata = {63'd0, r_cfg.mode};
            REG_LEFT:    prdata = {32'd0, r_cfg.left_edge};
            REG_TOP:     prdata = {32'd0, r_cfg.top_edge};
            REG_STEP_X:  prdata = {32'd0, r_cfg.step_x};
            REG_STEP_Y:  prdata = {32'd0, r_cfg.step_y};
            REG_SEED:    prdata = r_cfg.seed;
            REG_LIMIT:   prdata = {{(64-LIMIT_W){1'b0}}, r_cfg.limit};
            REG_BAILOUT: prdata = r_cfg.bailout;
            default:     prdata = 64'd0;
        endcase
    end

endmodule

FILE: rtl/ftcm_dp.sv
// ----------------------------------------------------------------------------
// ftcm_dp
// Datapath: plane mapping, shared 32x32 multiplier with 128-bit accumulator,
// saturating update and a radix-2 divider for the back mapping.
// ----------------------------------------------------------------------------
module ftcm_dp
    import ftcm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_dp_cmd            i_cmd,
    input  logic [15:0]        i_pix_x,
    input  logic [15:0]        i_pix_y,
    output t_dp_sts            o_sts,
    output logic signed [31:0] o_src_x,
    output logic signed [31:0] o_src_y,
    output logic               o_saturated
);

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    // {overflow, value}
    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return {1'b1, s[64] ? S64_MIN : S64_MAX};
        return {1'b0, s[63:0]};
    endfunction

    function automatic logic [64:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return {1'b1, s[64] ? S64_MIN : S64_MAX};
        return {1'b0, s[63:0]};
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    logic [15:0]        r_px, r_py;
    logic signed [48:0] r_prx, r_pry;
    logic [63:0]        r_zx, r_zy, r_kx, r_ky;
    logic [63:0]        r_max, r_may;
    logic               r_sgx, r_sgy;
    logic [63:0]        r_prod;
    logic [127:0]       r_acc;
    logic [63:0]        r_x2, r_y2, r_xy, r_t1, r_t2;
    logic               r_esc, r_sat;
    logic [63:0]        r_d;
    logic [DIV_STEPS-1:0] r_dvd;
    logic [31:0]        r_ms, r_rem, r_q;
    logic               r_qovf, r_neg;
    logic [31:0]        r_res_x, r_res_y;
    logic [31:0]        r_src_x, r_src_y;
    logic               r_out_sat;

    // plane point
    logic [63:0] cx, cy;
    assign cx = {{32{i_cfg.left_edge[31]}}, i_cfg.left_edge} + {{15{r_prx[48]}}, r_prx};
    assign cy = {{32{i_cfg.top_edge[31]}}, i_cfg.top_edge} + {{15{r_pry[48]}}, r_pry};

    // multiplier operand selection
    logic [63:0] op_a, op_b;
    logic [31:0] half_a, half_b;
    assign op_a   = (i_cmd.sel_m == MUL_YY) ? r_may : r_max;
    assign op_b   = (i_cmd.sel_m == MUL_XX) ? r_max : r_may;
    assign half_a = i_cmd.sel_p[1] ? op_a[63:32] : op_a[31:0];
    assign half_b = i_cmd.sel_p[0] ? op_b[63:32] : op_b[31:0];

    // aligned partial product
    logic [127:0] pp_aligned;
    always_comb begin
        case (i_cmd.sel_p)
            2'd0:    pp_aligned = {64'd0, r_prod};
            2'd3:    pp_aligned = {r_prod, 64'd0};
            default: pp_aligned = {32'd0, r_prod, 32'd0};
        endcase
    end

    // fixed-point product: truncate magnitude, sign, saturate
    logic        f_neg, f_sat;
    logic [63:0] f_lo, f_val;
    always_comb begin
        f_neg = (i_cmd.sel_m == MUL_XY) && (r_sgx ^ r_sgy);
        f_lo  = r_acc[FRAC_BITS+63:FRAC_BITS];
        f_sat = 1'b0;
        if (r_acc[127:FRAC_BITS+64] != '0) begin
            f_sat = 1'b1;
            f_val = f_neg ? S64_MIN : S64_MAX;
        end else if (f_neg) begin
            f_sat = f_lo > S64_MIN;
            f_val = f_sat ? S64_MIN : (~f_lo + 64'd1);
        end else begin
            f_sat = f_lo[63];
            f_val = f_sat ? S64_MAX : f_lo;
        end
    end

    // iteration update
    logic [63:0] m2;
    logic [64:0] u1, u2, u3, u4;
    assign m2 = r_x2 + r_y2;
    assign u1 = sat_sub(r_x2, r_y2);
    assign u2 = sat_add(r_xy, r_xy);
    assign u3 = sat_add(r_t1, r_kx);
    assign u4 = sat_add(r_t2, r_ky);

    // back mapping operands
    logic [63:0]        b_z;
    logic signed [31:0] b_edge, b_step;
    logic [64:0]        b_d;
    assign b_z    = i_cmd.axis ? r_zy : r_zx;
    assign b_edge = i_cmd.axis ? i_cfg.top_edge : i_cfg.left_edge;
    assign b_step = i_cmd.axis ? i_cfg.step_y : i_cfg.step_x;
    assign b_d    = sat_sub(b_z, {{32{b_edge[31]}}, b_edge});

    // divider step
    logic [32:0] rem_sh;
    logic        q_bit;
    assign rem_sh = {r_rem, r_dvd[DIV_STEPS-1]};
    assign q_bit  = rem_sh >= {1'b0, r_ms};

    // final clamp of the quotient
    logic [32:0] q_lim;
    logic        q_over;
    logic [31:0] q_val;
    assign q_lim  = r_neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    assign q_over = r_qovf || ({1'b0, r_q} > q_lim);
    assign q_val  = q_over ? q_lim[31:0] : r_q;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pix_x;
            r_py <= i_pix_y;
        end
        if (i_cmd.init_mul) begin
            r_prx <= $signed({1'b0, r_px}) * i_cfg.step_x;
            r_pry <= $signed({1'b0, r_py}) * i_cfg.step_y;
        end
        if (i_cmd.init_add) begin
            r_zx <= cx;
            r_zy <= cy;
            r_kx <= (i_cfg.mode == MODE_JULIA) ?
                    {{32{i_cfg.seed[31]}}, i_cfg.seed[31:0]} : cx;
            r_ky <= (i_cfg.mode == MODE_JULIA) ?
                    {{32{i_cfg.seed[63]}}, i_cfg.seed[63:32]} : cy;
        end
        if (i_cmd.prep) begin
            r_max <= mag64(r_zx);
            r_may <= mag64(r_zy);
            r_sgx <= r_zx[63];
            r_sgy <= r_zy[63];
            r_acc <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= half_a * half_b;
        end
        if (i_cmd.acc) begin
            r_acc <= r_acc + pp_aligned;
        end
        if (i_cmd.fin) begin
            r_acc <= '0;
            case (i_cmd.sel_m)
                MUL_XX:  r_x2 <= f_val;
                MUL_YY:  r_y2 <= f_val;
                default: r_xy <= f_val;
            endcase
        end
        if (i_cmd.upd1) begin
            r_t1 <= u1[63:0];
            r_t2 <= u2[63:0];
        end
        if (i_cmd.upd2) begin
            r_zx <= u3[63:0];
            r_zy <= u4[63:0];
        end
        if (i_cmd.bsub) begin
            r_d <= b_d[63:0];
            if (b_step == '0) begin
                if (i_cmd.axis) r_res_y <= '0;
                else            r_res_x <= '0;
            end
        end
        if (i_cmd.bmag) begin
            r_dvd  <= {mag64(r_d), {OUT_FRAC{1'b0}}};
            r_ms   <= b_step[31] ? (~b_step + 32'd1) : b_step;
            r_neg  <= r_d[63] ^ b_step[31];
            r_rem  <= '0;
            r_q    <= '0;
            r_qovf <= 1'b0;
        end
        if (i_cmd.div) begin
            r_rem  <= q_bit ? 32'(rem_sh - {1'b0, r_ms}) : rem_sh[31:0];
            r_q    <= {r_q[30:0], q_bit};
            r_qovf <= r_qovf | r_q[31];
            r_dvd  <= {r_dvd[DIV_STEPS-2:0], 1'b0};
        end
        if (i_cmd.bfin) begin
            if (i_cmd.axis) r_res_y <= r_neg ? (~q_val + 32'd1) : q_val;
            else            r_res_x <= r_neg ? (~q_val + 32'd1) : q_val;
        end
        if (i_cmd.out_load) begin
            r_src_x   <= r_res_x;
            r_src_y   <= r_res_y;
            r_out_sat <= r_sat;
        end
    end

    // escape flag and clamp flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
            r_sat <= 1'b0;
        end else begin
            if (i_cmd.upd1) r_esc <= m2 > i_cfg.bailout;
            if (i_cmd.load) begin
                r_sat <= 1'b0;
            end else begin
                if (i_cmd.fin && f_sat)            r_sat <= 1'b1;
                if (i_cmd.upd1 && (u1[64] || u2[64])) r_sat <= 1'b1;
                if (i_cmd.upd2 && (u3[64] || u4[64])) r_sat <= 1'b1;
                if (i_cmd.bsub && ((b_step == '0) || b_d[64])) r_sat <= 1'b1;
                if (i_cmd.bfin && q_over)          r_sat <= 1'b1;
            end
        end
    end

    assign o_sts.esc       = r_esc;
    assign o_sts.step_zero = (b_step == '0);
    assign o_src_x         = r_src_x;
    assign o_src_y         = r_src_y;
    assign o_saturated     = r_out_sat;

endmodule

FILE: rtl/ftcm_ctrl.sv
// ----------------------------------------------------------------------------
// ftcm_ctrl
// Sequencer: walks the datapath through mapping, iterations and division,
// and owns both handshakes.
// ----------------------------------------------------------------------------
module ftcm_ctrl
    import ftcm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [LIMIT_W-1:0] i_limit,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  t_dp_sts            i_sts,
    output t_dp_cmd            o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'h0001,
        S_INIT_MUL = 14'h0002,
        S_INIT_ADD = 14'h0004,
        S_PREP     = 14'h0008,
        S_MUL      = 14'h0010,
        S_ACC      = 14'h0020,
        S_FIN      = 14'h0040,
        S_UPD1     = 14'h0080,
        S_UPD2     = 14'h0100,
        S_BSUB     = 14'h0200,
        S_BMAG     = 14'h0400,
        S_DIV      = 14'h0800,
        S_BFIN     = 14'h1000,
        S_OUT      = 14'h2000
    } t_state;

    t_state               r_state, n_state;
    logic [1:0]           r_m, n_m, r_p, n_p;
    logic [LIMIT_W-1:0]   r_iter, n_iter;
    logic                 r_axis, n_axis;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [LIMIT_W-1:0]   lim_eff;
    logic                 out_free;

    assign lim_eff  = (i_limit > MAX_ITER) ? MAX_ITER : i_limit;
    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state     = r_state;
        n_m         = r_m;
        n_p         = r_p;
        n_iter      = r_iter;
        n_axis      = r_axis;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_INIT_MUL;
            end
            S_INIT_MUL: n_state = S_INIT_ADD;
            S_INIT_ADD: begin
                n_iter  = '0;
                n_axis  = 1'b0;
                n_state = (lim_eff == '0) ? S_BSUB : S_PREP;
            end
            S_PREP: begin
                n_m     = MUL_XX;
                n_p     = 2'd0;
                n_state = S_MUL;
            end
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                if (r_p == 2'd3) begin
                    n_state = S_FIN;
                end else begin
                    n_p     = r_p + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                n_p = 2'd0;
                if (r_m == MUL_XY) begin
                    n_state = S_UPD1;
                end else begin
                    n_m     = r_m + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_UPD1: n_state = S_UPD2;
            S_UPD2: begin
                n_m = MUL_XX;
                if (i_sts.esc || (r_iter + 17'd1 == lim_eff)) begin
                    n_state = S_BSUB;
                end else begin
                    n_iter  = r_iter + 17'd1;
                    n_state = S_PREP;
                end
            end
            S_BSUB: begin
                if (!i_sts.step_zero) begin
                    n_state = S_BMAG;
                end else if (r_axis) begin
                    n_state = S_OUT;
                end else begin
                    n_axis = 1'b1;
                end
            end
            S_BMAG: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = S_BFIN;
                else n_cnt = r_cnt + 1'b1;
            end
            S_BFIN: begin
                if (r_axis) begin
                    n_state = S_OUT;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_BSUB;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_m         <= MUL_XX;
            r_p         <= 2'd0;
            r_iter      <= '0;
            r_axis      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_m         <= n_m;
            r_p         <= n_p;
            r_iter      <= n_iter;
            r_axis      <= n_axis;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.init_mul = (r_state == S_INIT_MUL);
        o_cmd.init_add = (r_state == S_INIT_ADD);
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.acc      = (r_state == S_ACC);
        o_cmd.fin      = (r_state == S_FIN);
        o_cmd.upd1     = (r_state == S_UPD1);
        o_cmd.upd2     = (r_state == S_UPD2);
        o_cmd.bsub     = (r_state == S_BSUB);
        o_cmd.bmag     = (r_state == S_BMAG);
        o_cmd.div      = (r_state == S_DIV);
        o_cmd.bfin     = (r_state == S_BFIN);
        o_cmd.out_load = (r_state == S_OUT) && out_free;
        o_cmd.sel_m    = r_m;
        o_cmd.sel_p    = r_p;
        o_cmd.axis     = r_axis;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> r_state == S_INIT_MUL)
        else $error("accepted transaction did not start mapping");
    a_mul_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_m != 2'd3))
        else $error("invalid product selector");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD2) |-> (r_iter < lim_eff))
        else $error("iteration count beyond limit");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= DIV_CNT_W'(DIV_STEPS - 1)))
        else $error("divider step count overrun");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented after load");

endmodule

FILE: rtl/fractal_trace_coordinate_map.sv
// ----------------------------------------------------------------------------
// fractal_trace_coordinate_map
// Maps an output pixel to the source sample position through a fractal
// escape-time iteration.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid/o_in_ready carries one pixel (i_pix_x, i_pix_y).
//   Output channel o_out_valid/i_out_ready carries (o_src_x, o_src_y,
//   o_saturated), one result per pixel, in order.
//   Configuration is written over the APB port (64-bit data, register i at
//   byte address 8*i); the user must write it only while the block is
//   idle, which the block itself does not enforce. One pixel is worked
//   on at a time. Iterations run until the point escapes or the limit is
//   reached; an axis with a zero step skips the division.
//   Each iteration forms three 64x64 products as four 32x32 partial
//   products each on one shared multiplier; each back-mapped axis is a
//   76-step restoring division, one quotient bit per cycle.
//   A finished result sits in the output register; a new pixel is taken
//   while it waits. If the result register is still full when the next
//   result is ready, the sequencer holds until the receiver takes it.
//   Reset (synchronous, active low) restores default registers and empties
//   the output register.
// ----------------------------------------------------------------------------
module fractal_trace_coordinate_map
    import ftcm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_pix_x,
    input  logic [15:0]        i_pix_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_src_x,
    output logic signed [31:0] o_src_y,
    output logic               o_saturated
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // configuration registers
    ftcm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer
    ftcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (cfg.limit),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic
    ftcm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_pix_x     (i_pix_x),
        .i_pix_y     (i_pix_y),
        .o_sts       (sts),
        .o_src_x     (o_src_x),
        .o_src_y     (o_src_y),
        .o_saturated (o_saturated)
    );

endmodule
